### src/ngts_pkg.sv
package ngts_pkg;

    localparam int MAX_CELLS = 316;
    localparam int FRAC_BITS = 16;

    localparam int CELL_W  = 9;
    localparam int FW_W    = 16;
    localparam int LABEL_W = 17;
    localparam int DU_W    = FRAC_BITS + 1;
    localparam int SU_W    = 25;
    localparam int SEG_W   = 32;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_CELL_COUNT  = 2'd0;
    localparam logic [1:0] REG_FONT_WEIGHT = 2'd1;

    // Segment geometry on a scale of 100 * 2^(FRAC_BITS+2) per digit box.
    localparam logic signed [SEG_W-1:0] SEG_Q = 32'sd26214400;
    localparam logic signed [SEG_W-1:0] SEG_M = 32'sd2621440;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic               chk;
        logic               ok;
        logic [2:0]         pow_sel;
        logic [DU_W-1:0]    du;
        logic [FRAC_BITS-1:0] cv;
    } cell_res_t;

    typedef struct packed {
        logic [LABEL_W-1:0]     label;
        logic                   chk;
        logic                   ok;
        logic [3:0]             digit;
        logic [SU_W-1:0]        su;
        logic signed [SEG_W-1:0] vv;
        logic                   low;
    } digit_res_t;

    // Lit segments of a decimal digit, bit s for segment s.
    function automatic logic [7:0] lit_mask(input logic [3:0] d);
        logic [7:0] r;
        case (d)
            4'd0: r = 8'hEE;
            4'd1: r = 8'h28;
            4'd2: r = 8'hDA;
            4'd3: r = 8'hBA;
            4'd4: r = 8'h3C;
            4'd5: r = 8'hB6;
            4'd6: r = 8'hF6;
            4'd7: r = 8'h2A;
            4'd8: r = 8'hFE;
            4'd9: r = 8'hBE;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Reciprocal of 10^k on a scale of 2^34, rounded up.
    function automatic logic [30:0] recip_pow10(input logic [2:0] k);
        logic [30:0] r;
        case (k)
            3'd1: r = 31'd1717986919;
            3'd2: r = 31'd171798692;
            3'd3: r = 31'd17179870;
            3'd4: r = 31'd1717987;
            default: r = 31'd0;
        endcase
        return r;
    endfunction

    // Digits needed for the largest label, cells^2 - 1.
    function automatic logic [2:0] digit_count(input logic [CELL_W-1:0] c);
        logic [2:0] r;
        if (c <= 9'd3)
            r = 3'd1;
        else if (c <= 9'd10)
            r = 3'd2;
        else if (c <= 9'd31)
            r = 3'd3;
        else if (c <= 9'd100)
            r = 3'd4;
        else
            r = 3'd5;
        return r;
    endfunction

endpackage

### src/numbered_grid_texel_shader_top.sv
// Numbered grid texel shader. Each transaction on the input carries one texture
// coordinate (u_frac, v_frac) in unsigned Q0.16; each output transaction gives the
// checker parity of the grid cell, the cell number counted row-major from the
// left end of the row at the largest v_frac, and whether the point sits on a
// lit seven-segment stroke of that number drawn in the cell. The block is a
// five-stage pipeline that accepts one transaction per clock while in_stall is
// low. A result is presented on the output once it reaches the output register,
// and it is held there while out_stall is high. The stages are the coordinate
// scaling multipliers, the label multiply, the power-of-ten quotient, the decimal
// digit extraction, and the segment compare into the output register. Write
// cell_count and font_weight only while no transaction is in flight.
module numbered_grid_texel_shader_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] u_frac,
    input  logic [15:0] v_frac,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        checker_pick,
    output logic        on_digit,
    output logic [16:0] cell_label
);

    logic [8:0]  cell_count_reg;
    logic [15:0] font_weight_reg;
    logic [8:0]  cells;

    // One valid bit per stage; stage 5 is the output register.
    logic [5:1] vld_reg;
    logic [5:1] vld_next;
    logic [5:1] rdy;
    ngts_pkg::stage_en_t en;

    ngts_pkg::cell_res_t  cell_res;
    ngts_pkg::digit_res_t digit_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_count_reg  <= 9'd10;
            font_weight_reg <= 16'd32768;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ngts_pkg::REG_CELL_COUNT:  cell_count_reg  <= cfg_data[8:0];
                ngts_pkg::REG_FONT_WEIGHT: font_weight_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Counts above the supported grid are treated as the largest grid.
    assign cells = (cell_count_reg > 9'(ngts_pkg::MAX_CELLS)) ?
                   9'(ngts_pkg::MAX_CELLS) : cell_count_reg;

    // A stage may load when it is empty or the stage after it moves on.
    always_comb
    begin
        rdy[5] = !vld_reg[5] || !out_stall;
        rdy[4] = !vld_reg[4] || rdy[5];
        rdy[3] = !vld_reg[3] || rdy[4];
        rdy[2] = !vld_reg[2] || rdy[3];
        rdy[1] = !vld_reg[1] || rdy[2];

        en.s1 = rdy[1];
        en.s2 = rdy[2];
        en.s3 = rdy[3];
        en.s4 = rdy[4];
        en.s5 = rdy[5];

        vld_next[1] = rdy[1] ? in_valid   : vld_reg[1];
        vld_next[2] = rdy[2] ? vld_reg[1] : vld_reg[2];
        vld_next[3] = rdy[3] ? vld_reg[2] : vld_reg[3];
        vld_next[4] = rdy[4] ? vld_reg[3] : vld_reg[4];
        vld_next[5] = rdy[5] ? vld_reg[4] : vld_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !rdy[1];
    assign out_valid = vld_reg[5];

    ngts_cell u_cell
    (
        .clk    (clk),
        .en     (en),
        .cells  (cells),
        .u_frac (u_frac),
        .v_frac (v_frac),
        .res    (cell_res)
    );

    ngts_digit u_digit
    (
        .clk (clk),
        .en  (en),
        .cin (cell_res),
        .res (digit_res)
    );

    ngts_seg u_seg
    (
        .clk          (clk),
        .en           (en),
        .din          (digit_res),
        .font_weight  (font_weight_reg),
        .checker_pick (checker_pick),
        .on_digit     (on_digit),
        .cell_label   (cell_label)
    );

endmodule

### src/ngts_cell.sv
module ngts_cell
(
    input  logic                             clk,
    input  ngts_pkg::stage_en_t              en,
    input  logic [ngts_pkg::CELL_W-1:0]      cells,
    input  logic [ngts_pkg::FRAC_BITS-1:0]   u_frac,
    input  logic [ngts_pkg::FRAC_BITS-1:0]   v_frac,
    output ngts_pkg::cell_res_t              res
);

    logic [24:0] pu;
    logic [24:0] pv;
    logic [8:0]  col_reg;
    logic [8:0]  row_reg;
    logic [15:0] cu_reg;
    logic [15:0] cv_reg;

    logic [8:0]  rows_below;
    logic [17:0] label_w;
    logic [2:0]  ndig;
    logic [19:0] ten_cu;
    logic [19:0] box_off;
    logic [19:0] pos;
    logic [2:0]  idx;
    ngts_pkg::cell_res_t res_reg;
    ngts_pkg::cell_res_t res_next;

    assign pu = 25'(cells) * 25'(u_frac);
    assign pv = 25'(cells) * 25'(v_frac);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            col_reg <= pu[24:16];
            row_reg <= pv[24:16];
            cu_reg  <= pu[15:0];
            cv_reg  <= pv[15:0];
        end
    end

    always_comb
    begin
        rows_below = cells - 9'd1 - row_reg;
        label_w    = 18'(cells) * 18'(rows_below) + 18'(col_reg);
        ndig       = ngts_pkg::digit_count(cells);
        ten_cu     = 20'(cu_reg) * 20'd10;
        box_off    = 20'(3'd5 - ndig) << 16;
        pos        = ten_cu - box_off;
        idx        = pos[19:17];

        res_next.label   = (cells == 9'd0) ? 17'd0 : label_w[16:0];
        res_next.chk     = col_reg[0] ^ row_reg[0];
        res_next.ok      = (ten_cu >= box_off) && (idx < ndig);
        res_next.pow_sel = ndig - 3'd1 - idx;
        res_next.du      = pos[16:0];
        res_next.cv      = cv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### src/ngts_digit.sv
module ngts_digit
(
    input  logic                  clk,
    input  ngts_pkg::stage_en_t   en,
    input  ngts_pkg::cell_res_t   cin,
    output ngts_pkg::digit_res_t  res
);

    logic [47:0] quot_w;
    logic [16:0] quot_reg;
    logic [16:0] quot;
    logic [24:0] su;
    logic signed [31:0] sv;
    logic [16:0] label3_reg;
    logic        chk3_reg;
    logic        ok3_reg;
    logic [24:0] su3_reg;
    logic signed [31:0] sv3_reg;

    logic [35:0] q10_w;
    logic [16:0] q10;
    logic [16:0] rem;
    ngts_pkg::digit_res_t res_reg;
    ngts_pkg::digit_res_t res_next;

    // Integer quotient by the selected power of ten, through its reciprocal.
    always_comb
    begin
        quot_w = 48'(cin.label) * 48'(ngts_pkg::recip_pow10(cin.pow_sel));
        quot   = (cin.pow_sel == 3'd0) ? cin.label : 17'(quot_w >> 34);
        su     = 25'(cin.du) * 25'd200;
        sv     = (32'sd458752 - $signed({16'd0, cin.cv}) * 32'sd10) * 32'sd100;
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            quot_reg   <= quot;
            label3_reg <= cin.label;
            chk3_reg   <= cin.chk;
            ok3_reg    <= cin.ok;
            su3_reg    <= su;
            sv3_reg    <= sv;
        end
    end

    // Last decimal digit of the quotient; the lower half mirrors onto the upper.
    always_comb
    begin
        q10_w = 36'(quot_reg) * 36'd419431;
        q10   = 17'(q10_w >> 22);
        rem   = quot_reg - q10 * 17'd10;

        res_next.label = label3_reg;
        res_next.chk   = chk3_reg;
        res_next.ok    = ok3_reg;
        res_next.digit = rem[3:0];
        res_next.su    = su3_reg;
        res_next.low   = (sv3_reg <<< 1) > ngts_pkg::SEG_Q;
        res_next.vv    = res_next.low ? (ngts_pkg::SEG_Q - sv3_reg) : sv3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### src/ngts_seg.sv
module ngts_seg
(
    input  logic                           clk,
    input  ngts_pkg::stage_en_t            en,
    input  ngts_pkg::digit_res_t           din,
    input  logic [ngts_pkg::FW_W-1:0]      font_weight,
    output logic                           checker_pick,
    output logic                           on_digit,
    output logic [ngts_pkg::LABEL_W-1:0]   cell_label
);

    function automatic logic [2:0] upper_seg(
        input logic signed [31:0] u,
        input logic signed [31:0] v,
        input logic signed [31:0] t
    );
        logic signed [31:0] q;
        logic signed [31:0] m;
        logic [2:0] r;
        q = ngts_pkg::SEG_Q;
        m = ngts_pkg::SEG_M;
        if (u < 2 * m || q - 2 * m < u || v < m)
            r = 3'd0;
        else if (u > 2 * (m + t) && u < q - 2 * (m + t) && v > m + t && 2 * v < q - t)
            r = 3'd0;
        else if (u - 2 * v > 0 && u + 2 * v < q)
            r = 3'd1;
        else if (u + 4 * v > 2 * m + 2 * q && u - 4 * v < -2 * m - q)
            r = 3'd4;
        else if (2 * u < q)
            r = 3'd2;
        else
            r = 3'd3;
        return r;
    endfunction

    logic signed [31:0] thick;
    logic [2:0] seg_up;
    logic [2:0] seg;
    logic [7:0] mask;
    logic       chk_reg;
    logic       hit_reg;
    logic [16:0] label_reg;

    always_comb
    begin
        thick  = $signed(32'(font_weight) * 32'd48);
        seg_up = upper_seg($signed(32'(din.su)), din.vv, thick);
        seg    = din.low ? 3'(4'd8 - 4'(seg_up)) : seg_up;
        mask   = ngts_pkg::lit_mask(din.digit);
    end

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            chk_reg   <= din.chk;
            hit_reg   <= din.ok & mask[seg];
            label_reg <= din.label;
        end
    end

    assign checker_pick = chk_reg;
    assign on_digit     = hit_reg;
    assign cell_label   = label_reg;

endmodule
